>>> src/iee_pkg.sv
package iee_pkg;

  // ASCII codes of the accepted characters
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam int SCALE_STEPS = 16;
  localparam int SCALE_KW    = $clog2(SCALE_STEPS);

  localparam logic [63:0] VAL_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] VAL_MIN = 64'h8000_0000_0000_0000;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_MUL   = 3'd2,
    OP_DIV   = 3'd3,
    OP_PAREN = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_DIV_ZERO  = 3'd1,
    ERR_OVERFLOW  = 3'd2,
    ERR_MALFORMED = 3'd3,
    ERR_SATURATED = 3'd4
  } err_t;

  typedef enum logic [2:0] {
    CC_DIGIT,
    CC_POINT,
    CC_OPEN,
    CC_CLOSE,
    CC_OP,
    CC_BAD
  } char_class_t;

  typedef enum logic [1:0] {
    PH_NONE = 2'd0,
    PH_INT  = 2'd1,
    PH_FRAC = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] char_in;
    logic       last_char;
  } item_t;

  typedef struct packed {
    logic signed [63:0] result_value;
    logic [2:0]         error_code;
  } result_t;

  typedef struct packed {
    logic accept;
    logic digit;
    logic point;
    logic finish_num;
    logic push_paren;
    logic push_op;
    logic op_pop;
    logic v_rd_second;
    logic cap_x2;
    logic cap_x1;
    logic alu_start;
    logic push_res;
    logic flag_malformed;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    char_class_t cclass;
    logic        last;
    op_t         top_op;
    op_t         new_op;
    logic        otop_zero;
    logic        vtop_lt2;
    logic        vtop_one;
    logic        alu_done;
    logic        out_free;
  } status_t;

  function automatic char_class_t char_class(input logic [7:0] c);
    char_class_t r;
    unique case (c) inside
      [CH_ZERO:CH_NINE]:                     r = CC_DIGIT;
      CH_DOT:                                r = CC_POINT;
      CH_LPAR:                               r = CC_OPEN;
      CH_RPAR:                               r = CC_CLOSE;
      CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH:  r = CC_OP;
      default:                               r = CC_BAD;
    endcase
    return r;
  endfunction

  function automatic op_t char_op(input logic [7:0] c);
    op_t r;
    unique case (c)
      CH_MINUS: r = OP_SUB;
      CH_STAR:  r = OP_MUL;
      CH_SLASH: r = OP_DIV;
      default:  r = OP_ADD;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] prec(input op_t op);
    logic [1:0] r;
    unique case (op) inside
      OP_ADD, OP_SUB: r = 2'd1;
      OP_MUL, OP_DIV: r = 2'd2;
      default:        r = 2'd0;
    endcase
    return r;
  endfunction

  // keep the first hard error; saturation gives way to any hard error
  function automatic err_t flag_apply(input err_t cur, input err_t e);
    err_t r;
    r = cur;
    if (e != ERR_NONE) begin
      if (cur == ERR_NONE || (cur == ERR_SATURATED && e != ERR_SATURATED)) begin
        r = e;
      end
    end
    return r;
  endfunction

  // {saturated, signed value} from a magnitude and a sign
  function automatic logic [64:0] from_mag(input logic [63:0] m, input logic neg);
    logic [63:0] lim;
    logic [63:0] v;
    logic        sat;
    lim = neg ? VAL_MIN : VAL_MAX;
    sat = m > lim;
    v   = sat ? lim : m;
    return {sat, (neg ? 64'(64'd0 - v) : v)};
  endfunction

  // fraction digit weights: one tenth, then (s + 5) / 10 per digit
  function automatic logic [SCALE_STEPS*64-1:0] scale_table(input int frac_bits);
    logic [63:0]               s;
    logic [SCALE_STEPS*64-1:0] t;
    s = ((64'd1 << frac_bits) + 64'd5) / 64'd10;
    t = '0;
    for (int i = 0; i < SCALE_STEPS; i++) begin
      t[i*64 +: 64] = s;
      s = (s + 64'd5) / 64'd10;
    end
    return t;
  endfunction

endpackage

>>> src/iee_ram.sv
module iee_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/iee_dp.sv
module iee_dp #(
  parameter int STACK_DEPTH = 64,
  parameter int FRAC_BITS   = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  iee_pkg::item_t    item,
  input  iee_pkg::cmd_t     cmd,
  output iee_pkg::status_t  status,
  output iee_pkg::result_t  result,
  output logic              result_valid,
  input  logic              result_stall
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [iee_pkg::SCALE_STEPS*64-1:0] SCALE_TAB = iee_pkg::scale_table(FRAC_BITS);
  localparam logic [6:0] DIV_LAST = 7'd127;
  localparam logic [6:0] MUL_LAST = 7'd3;

  logic [7:0]            char_q;
  logic                  last_q;
  logic [CW-1:0]         vtop;
  logic [CW-1:0]         otop;
  logic [63:0]           acc;
  iee_pkg::phase_t       phase;
  logic [iee_pkg::SCALE_KW-1:0] k;
  iee_pkg::err_t         err;
  iee_pkg::err_t         err_next;

  logic [63:0]           x1;
  logic [63:0]           x2;
  iee_pkg::op_t          alu_op;
  logic [63:0]           ma;
  logic [63:0]           mb;
  logic                  neg;
  logic                  is_mul;
  logic [127:0]          prod;
  logic [63:0]           q;
  logic [63:0]           rem;
  logic                  ov;
  logic [6:0]            cnt;
  logic                  run;
  logic                  fin;
  logic                  done;
  logic [63:0]           res;

  logic [63:0]           vdata;
  logic [2:0]            odata;

  // number accumulation
  logic [3:0]   d;
  logic [63:0]  scale;
  logic [63:0]  frac_add;
  logic [64:0]  frac_sum;
  logic [67:0]  int_sum;
  logic         num_sat;

  // stack control
  logic         vfull;
  logic         ofull;
  logic         v_push_num;
  logic         v_we;
  logic [63:0]  v_wdata;
  logic [AW-1:0] v_raddr;
  logic         o_we;
  logic [2:0]   o_wdata;

  // arithmetic
  logic [63:0]  mag1;
  logic [63:0]  mag2;
  logic [63:0]  add_s;
  logic [63:0]  sub_s;
  logic         add_ov;
  logic         sub_ov;
  logic [63:0]  ah;
  logic [63:0]  bh;
  logic [127:0] part_sh;
  logic [64:0]  r2;
  logic         take;
  logic [63:0]  mul_m;
  logic         mul_ovf;
  logic [63:0]  fin_m;
  logic [64:0]  fm;
  logic [63:0]  out_val;
  iee_pkg::err_t e_num;
  iee_pkg::err_t e_vpush;
  iee_pkg::err_t e_opush;
  iee_pkg::err_t e_alu;

  iee_ram #(.WIDTH(64), .DEPTH(STACK_DEPTH)) u_vram (
    .clk  (clk),
    .we   (v_we),
    .waddr(vtop[AW-1:0]),
    .wdata(v_wdata),
    .raddr(v_raddr),
    .rdata(vdata)
  );

  iee_ram #(.WIDTH(3), .DEPTH(STACK_DEPTH)) u_oram (
    .clk  (clk),
    .we   (o_we),
    .waddr(otop[AW-1:0]),
    .wdata(o_wdata),
    .raddr(AW'(otop - CW'(1))),
    .rdata(odata)
  );

  assign d        = char_q[3:0];
  assign scale    = SCALE_TAB[k*64 +: 64];
  assign frac_add = 64'({60'd0, d} * scale);
  assign frac_sum = {1'b0, acc} + {1'b0, frac_add};
  assign int_sum  = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + (68'(d) << FRAC_BITS);
  assign num_sat  = (phase == iee_pkg::PH_FRAC) ? (frac_sum > {1'b0, iee_pkg::VAL_MAX})
                                                : (int_sum > 68'(iee_pkg::VAL_MAX));

  assign vfull      = vtop == CW'(STACK_DEPTH);
  assign ofull      = otop == CW'(STACK_DEPTH);
  assign v_push_num = cmd.finish_num && (phase != iee_pkg::PH_NONE);
  assign v_we       = (v_push_num && !vfull) || cmd.push_res;
  assign v_wdata    = cmd.push_res ? res : acc;
  assign v_raddr    = cmd.v_rd_second ? AW'(vtop - CW'(2)) : AW'(vtop - CW'(1));
  assign o_we       = (cmd.push_paren || cmd.push_op) && !ofull;
  assign o_wdata    = cmd.push_paren ? iee_pkg::OP_PAREN : iee_pkg::char_op(char_q);

  assign mag1   = x1[63] ? 64'(64'd0 - x1) : x1;
  assign mag2   = x2[63] ? 64'(64'd0 - x2) : x2;
  assign add_s  = x1 + x2;
  assign sub_s  = x1 - x2;
  assign add_ov = (x1[63] == x2[63]) && (add_s[63] != x1[63]);
  assign sub_ov = (x1[63] != x2[63]) && (sub_s[63] != x1[63]);

  // one 32x32 partial product per step
  assign ah      = {32'd0, (cnt[1] ? ma[63:32] : ma[31:0])};
  assign bh      = {32'd0, (cnt[0] ? mb[63:32] : mb[31:0])};
  assign part_sh = {64'd0, 64'(ah * bh)} << {cnt[1] & cnt[0], cnt[1] ^ cnt[0], 5'd0};

  // one restoring divide step
  assign r2   = {rem, prod[127]};
  assign take = r2 >= {1'b0, mb};

  assign mul_m   = 64'(prod >> FRAC_BITS);
  assign mul_ovf = (prod >> (64 + FRAC_BITS)) != 128'd0;
  assign fin_m   = is_mul ? (mul_ovf ? '1 : mul_m) : (ov ? '1 : q);
  assign fm      = iee_pkg::from_mag(fin_m, neg);

  always_comb begin
    e_num = iee_pkg::ERR_NONE;
    if (cmd.digit && num_sat) begin
      e_num = iee_pkg::ERR_SATURATED;
    end
    if ((cmd.point && phase == iee_pkg::PH_FRAC) || cmd.flag_malformed) begin
      e_num = iee_pkg::ERR_MALFORMED;
    end
    e_vpush = (v_push_num && vfull) ? iee_pkg::ERR_OVERFLOW : iee_pkg::ERR_NONE;
    e_opush = ((cmd.push_paren || cmd.push_op) && ofull) ? iee_pkg::ERR_OVERFLOW
                                                         : iee_pkg::ERR_NONE;
    e_alu = iee_pkg::ERR_NONE;
    if (cmd.alu_start) begin
      if ((alu_op == iee_pkg::OP_ADD && add_ov) || (alu_op == iee_pkg::OP_SUB && sub_ov)) begin
        e_alu = iee_pkg::ERR_SATURATED;
      end
      if (alu_op == iee_pkg::OP_DIV && x2 == 64'd0) begin
        e_alu = iee_pkg::ERR_DIV_ZERO;
      end
    end else if (fin && fm[64]) begin
      e_alu = iee_pkg::ERR_SATURATED;
    end
    err_next = iee_pkg::flag_apply(iee_pkg::flag_apply(iee_pkg::flag_apply(
               iee_pkg::flag_apply(err, e_num), e_vpush), e_opush), e_alu);
    if (cmd.out_load) begin
      err_next = iee_pkg::ERR_NONE;
    end
  end

  always_comb begin
    out_val = vdata;
    if (vtop == '0 || err == iee_pkg::ERR_DIV_ZERO || err == iee_pkg::ERR_OVERFLOW ||
        err == iee_pkg::ERR_MALFORMED) begin
      out_val = 64'd0;
    end
  end

  always_comb begin
    status.cclass    = iee_pkg::char_class(char_q);
    status.last      = last_q;
    status.top_op    = iee_pkg::op_t'(odata);
    status.new_op    = iee_pkg::char_op(char_q);
    status.otop_zero = otop == '0;
    status.vtop_lt2  = vtop < CW'(2);
    status.vtop_one  = vtop == CW'(1);
    status.alu_done  = done;
    status.out_free  = !result_valid || !result_stall;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      vtop         <= '0;
      otop         <= '0;
      acc          <= '0;
      phase        <= iee_pkg::PH_NONE;
      k            <= '0;
      err          <= iee_pkg::ERR_NONE;
      run          <= 1'b0;
      fin          <= 1'b0;
      done         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      err  <= err_next;
      done <= 1'b0;

      if (cmd.out_load || cmd.finish_num) begin
        acc   <= '0;
        phase <= iee_pkg::PH_NONE;
        k     <= '0;
      end else if (cmd.digit) begin
        if (phase == iee_pkg::PH_FRAC) begin
          acc <= num_sat ? iee_pkg::VAL_MAX : frac_sum[63:0];
          if (k != iee_pkg::SCALE_KW'(iee_pkg::SCALE_STEPS - 1)) begin
            k <= k + 1'b1;
          end
        end else begin
          phase <= iee_pkg::PH_INT;
          acc   <= num_sat ? iee_pkg::VAL_MAX : int_sum[63:0];
        end
      end else if (cmd.point && phase != iee_pkg::PH_FRAC) begin
        phase <= iee_pkg::PH_FRAC;
      end

      if (cmd.out_load) begin
        vtop <= '0;
      end else if (v_push_num && !vfull) begin
        vtop <= vtop + CW'(1);
      end else if (cmd.cap_x1) begin
        vtop <= vtop - CW'(2);
      end else if (cmd.push_res) begin
        vtop <= vtop + CW'(1);
      end

      if (cmd.out_load) begin
        otop <= '0;
      end else if (o_we) begin
        otop <= otop + CW'(1);
      end else if (cmd.op_pop) begin
        otop <= otop - CW'(1);
      end

      if (cmd.alu_start) begin
        if (alu_op == iee_pkg::OP_ADD || alu_op == iee_pkg::OP_SUB ||
            (alu_op == iee_pkg::OP_DIV && x2 == 64'd0)) begin
          done <= 1'b1;
        end else begin
          run <= 1'b1;
        end
      end else if (run) begin
        if ((is_mul && cnt == MUL_LAST) || (!is_mul && cnt == DIV_LAST)) begin
          run <= 1'b0;
          fin <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
      end

      if (cmd.out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      char_q <= item.char_in;
      last_q <= item.last_char;
    end
    if (cmd.cap_x2) begin
      x2 <= vdata;
    end
    if (cmd.cap_x1) begin
      x1 <= vdata;
    end
    if (cmd.op_pop) begin
      alu_op <= iee_pkg::op_t'(odata);
    end
    if (cmd.out_load) begin
      result.result_value <= out_val;
      result.error_code   <= err;
    end

    if (cmd.alu_start) begin
      ma     <= mag1;
      mb     <= mag2;
      neg    <= x1[63] ^ x2[63];
      is_mul <= alu_op == iee_pkg::OP_MUL;
      prod   <= (alu_op == iee_pkg::OP_MUL) ? 128'd0 : ({64'd0, mag1} << FRAC_BITS);
      rem    <= '0;
      q      <= '0;
      ov     <= 1'b0;
      cnt    <= '0;
      case (alu_op)
        iee_pkg::OP_ADD: res <= add_ov ? (x1[63] ? iee_pkg::VAL_MIN : iee_pkg::VAL_MAX) : add_s;
        iee_pkg::OP_SUB: res <= sub_ov ? (x1[63] ? iee_pkg::VAL_MIN : iee_pkg::VAL_MAX) : sub_s;
        default:         res <= 64'd0;
      endcase
    end else if (run) begin
      cnt <= cnt + 1'b1;
      if (is_mul) begin
        prod <= prod + part_sh;
      end else begin
        prod <= {prod[126:0], 1'b0};
        rem  <= take ? 64'(r2 - {1'b0, mb}) : r2[63:0];
        if (q[63]) begin
          ov <= 1'b1;
        end
        q <= {q[62:0], take};
      end
    end else if (fin) begin
      res <= fm[63:0];
    end
  end

endmodule

>>> src/iee_ctrl.sv
module iee_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  iee_pkg::status_t  status,
  output iee_pkg::cmd_t     cmd
);

  typedef enum logic [11:0] {
    S_IDLE     = 12'b0000_0000_0001,
    S_DECODE   = 12'b0000_0000_0010,
    S_LAST     = 12'b0000_0000_0100,
    S_OPS_RD   = 12'b0000_0000_1000,
    S_OPS_CHK  = 12'b0000_0001_0000,
    S_RED_RD   = 12'b0000_0010_0000,
    S_RED_X2   = 12'b0000_0100_0000,
    S_RED_X1   = 12'b0000_1000_0000,
    S_EXEC     = 12'b0001_0000_0000,
    S_WAIT     = 12'b0010_0000_0000,
    S_FINAL    = 12'b0100_0000_0000,
    S_FIN_WAIT = 12'b1000_0000_0000
  } state_t;

  typedef enum logic [1:0] {
    MODE_CLOSE,
    MODE_OP,
    MODE_DRAIN
  } mode_t;

  state_t state;
  state_t state_next;
  mode_t  mode;
  mode_t  mode_next;
  logic   stop_op;

  assign item_stall = state != S_IDLE;
  assign stop_op    = status.top_op == iee_pkg::OP_PAREN ||
                      iee_pkg::prec(status.top_op) < iee_pkg::prec(status.new_op);

  always_comb begin
    state_next = state;
    mode_next  = mode;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.accept = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_LAST;
        case (status.cclass)
          iee_pkg::CC_DIGIT: cmd.digit = 1'b1;
          iee_pkg::CC_POINT: cmd.point = 1'b1;
          iee_pkg::CC_OPEN: begin
            cmd.finish_num = 1'b1;
            cmd.push_paren = 1'b1;
          end
          iee_pkg::CC_CLOSE: begin
            cmd.finish_num = 1'b1;
            mode_next      = MODE_CLOSE;
            state_next     = S_OPS_RD;
          end
          iee_pkg::CC_OP: begin
            cmd.finish_num = 1'b1;
            mode_next      = MODE_OP;
            state_next     = S_OPS_RD;
          end
          default: cmd.flag_malformed = 1'b1;
        endcase
      end
      S_LAST: begin
        if (status.last) begin
          cmd.finish_num = 1'b1;
          mode_next      = MODE_DRAIN;
          state_next     = S_OPS_RD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_OPS_RD: begin
        if (status.otop_zero) begin
          case (mode)
            MODE_CLOSE: begin
              cmd.flag_malformed = 1'b1;
              state_next         = S_LAST;
            end
            MODE_OP: begin
              cmd.push_op = 1'b1;
              state_next  = S_LAST;
            end
            default: state_next = S_FINAL;
          endcase
        end else begin
          state_next = S_OPS_CHK;
        end
      end
      S_OPS_CHK: begin
        case (mode)
          MODE_CLOSE: begin
            cmd.op_pop = 1'b1;
            state_next = (status.top_op == iee_pkg::OP_PAREN) ? S_LAST : S_RED_RD;
          end
          MODE_OP: begin
            if (stop_op) begin
              cmd.push_op = 1'b1;
              state_next  = S_LAST;
            end else begin
              cmd.op_pop = 1'b1;
              state_next = S_RED_RD;
            end
          end
          default: begin
            cmd.op_pop = 1'b1;
            if (status.top_op == iee_pkg::OP_PAREN) begin
              cmd.flag_malformed = 1'b1;
              state_next         = S_OPS_RD;
            end else begin
              state_next = S_RED_RD;
            end
          end
        endcase
      end
      S_RED_RD: begin
        if (status.vtop_lt2) begin
          cmd.flag_malformed = 1'b1;
          state_next         = S_OPS_RD;
        end else begin
          state_next = S_RED_X2;
        end
      end
      S_RED_X2: begin
        cmd.cap_x2      = 1'b1;
        cmd.v_rd_second = 1'b1;
        state_next      = S_RED_X1;
      end
      S_RED_X1: begin
        cmd.cap_x1 = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.alu_start = 1'b1;
        state_next    = S_WAIT;
      end
      S_WAIT: begin
        if (status.alu_done) begin
          cmd.push_res = 1'b1;
          state_next   = S_OPS_RD;
        end
      end
      S_FINAL: begin
        cmd.flag_malformed = !status.vtop_one;
        state_next         = S_FIN_WAIT;
      end
      S_FIN_WAIT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mode  <= MODE_DRAIN;
    end else begin
      state <= state_next;
      mode  <= mode_next;
    end
  end

endmodule

>>> src/infix_expression_evaluator.sv
// A digit, point or '(' item passes the accept, decode and last-item states; each
// reduction adds the operand reads and the add, multiply or divide unit (one quotient
// bit per cycle, 128 steps). Throughput: one item at a time, set by the reduction loop
// over the operator stack and the shared iterative divider; once the drain empties the
// operator stack, the result is loaded, later while an earlier result is stalled.
// Reset (rst, synchronous): both stacks empty, number and error cleared, no result
// pending. Stack memories are not cleared; only entries below a stack top are read.
module infix_expression_evaluator #(
  parameter int STACK_DEPTH = 64,
  parameter int FRAC_BITS   = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  iee_pkg::item_t    item,
  output logic              result_valid,
  input  logic              result_stall,
  output iee_pkg::result_t  result
);

  // The controller steps through each item: decode the character, walk the
  // operator stack (pop, compare precedence, reduce), and on the final item
  // drain every operator and load the output register.
  iee_pkg::cmd_t    cmd;
  iee_pkg::status_t status;

  iee_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath holds the value and operator stacks (registered-read RAMs),
  // the number being read, the sticky error code, the add/subtract/multiply/divide unit
  // and the output register, which holds the result while the far side stalls.
  iee_dp #(
    .STACK_DEPTH(STACK_DEPTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .cmd         (cmd),
    .status      (status),
    .result      (result),
    .result_valid(result_valid),
    .result_stall(result_stall)
  );

endmodule
